### hdl/ctcp_pkg.sv
// Shared constants and types for the two-channel coincidence pairer.
`timescale 1ns / 1ps

package ctcp_pkg;

    // List geometry
    localparam int DEPTH      = 64;
    localparam int STAMP_BITS = 48;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port widths fixed by the interface
    localparam int MODE_W     = 2;
    localparam int IN_STAMP_W = 48;
    localparam int IDX_OUT_W  = 6;
    localparam int WIN_NS_W   = 20;

    // Window in picoseconds: 20-bit nanoseconds times 1000 fits in 30 bits
    localparam int WIN_W      = 30;
    localparam int SUM_W      = ((STAMP_BITS > WIN_W) ? STAMP_BITS : WIN_W) + 1;

    localparam logic [WIN_W-1:0] PS_PER_NS      = WIN_W'(1000);
    localparam logic [WIN_W-1:0] WIN_PS_RESET   = WIN_W'(10 * 1000);
    localparam logic [CNT_W-1:0] CNT_FULL       = CNT_W'(DEPTH);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // One result on its way to the output register
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic             last;
    } t_push;

endpackage

### hdl/ctcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ctcp_ram #(
    parameter int P_WIDTH = 48,
    parameter int P_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/two_channel_coincidence_pairer.sv
// Top level: list loading, two-pointer coincidence walk and result output.
`timescale 1ns / 1ps
// A load item produces nothing. A run item passes from idle through the walk state, one
// pointer step per walk cycle plus a step to see the end, to the finish state. The walk
// holds while a match meets a pending pair and the output is stalled, and the finish
// state waits while the output is stalled. A pair goes to the output register when the
// next pair is found, or in the finish state for the final pair.
// Reset (synchronous, active low) clears counts, overflow flag, walker and output
// valid, and sets the window to 10 ns. List RAMs are not cleared.

module two_channel_coincidence_pairer
    import ctcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [IN_STAMP_W-1:0] i_stamp_ps,
    // result item channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pair_found,
    output logic [IDX_OUT_W-1:0]  o_index_a,
    output logic [IDX_OUT_W-1:0]  o_index_b,
    output logic                  o_last,
    output logic                  o_overflowed,
    // window register write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WIN_NS_W-1:0]   i_cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt_a, r_cnt_b;
    logic                r_ovf;
    logic [WIN_W-1:0]    r_win_ps;
    logic [CNT_W-1:0]    r_ia, r_ib, n_ia, n_ib;

    // Pending pair: held back until we know whether it is the last one
    logic                r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]    r_pend_a, r_pend_b, n_pend_a, n_pend_b;

    // Output register
    logic                r_out_valid;
    logic                r_out_found;
    logic [IDX_W-1:0]    r_out_a, r_out_b;
    logic                r_out_last;
    logic                r_out_ovf;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic cfg_acc;

    assign o_stall     = (r_state != ST_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // ------------------------------------------------------------------
    // List RAMs: written at the fill count, read at the walk pointers
    // ------------------------------------------------------------------
    logic                  we_a, we_b;
    logic [STAMP_BITS-1:0] wdata;
    logic [STAMP_BITS-1:0] stamp_a, stamp_b;

    assign wdata = STAMP_BITS'(i_stamp_ps);
    assign we_a  = in_acc && (i_mode == MODE_LOAD_A) && (r_cnt_a < CNT_FULL);
    assign we_b  = in_acc && (i_mode == MODE_LOAD_B) && (r_cnt_b < CNT_FULL);

    ctcp_ram #(
        .P_WIDTH (STAMP_BITS),
        .P_DEPTH (DEPTH)
    ) u_list_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ia[IDX_W-1:0]),
        .o_rdata (stamp_a)
    );

    ctcp_ram #(
        .P_WIDTH (STAMP_BITS),
        .P_DEPTH (DEPTH)
    ) u_list_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ib[IDX_W-1:0]),
        .o_rdata (stamp_b)
    );

    // ------------------------------------------------------------------
    // Window compare on the stamps read for the current pointers
    // ------------------------------------------------------------------
    logic walk_done;
    logic a_late;   // A is beyond B plus window: advance B
    logic b_late;   // B is beyond A plus window: advance A

    assign walk_done = (r_ia >= r_cnt_a) || (r_ib >= r_cnt_b);
    assign a_late    = SUM_W'(stamp_a) > (SUM_W'(stamp_b) + SUM_W'(r_win_ps));
    assign b_late    = SUM_W'(stamp_b) > (SUM_W'(stamp_a) + SUM_W'(r_win_ps));

    // ------------------------------------------------------------------
    // Walk control. The next pointers also address the RAMs, so one step
    // completes per cycle. A match with a pending pair and a full, stalled output
    // register holds the pointers and re-reads the same entries.
    // ------------------------------------------------------------------
    t_push push;
    logic  clear_run;

    always_comb begin
        n_state      = r_state;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_pend_valid = r_pend_valid;
        n_pend_a     = r_pend_a;
        n_pend_b     = r_pend_b;
        push         = '0;
        clear_run    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_mode == MODE_RUN)) begin
                    n_state = ST_WALK;
                    n_ia    = '0;
                    n_ib    = '0;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_FIN;
                end else if (a_late) begin
                    n_ib = r_ib + 1'b1;
                end else if (b_late) begin
                    n_ia = r_ia + 1'b1;
                end else if (!r_pend_valid || out_free) begin
                    // release the previous pair, not last
                    push.valid   = r_pend_valid;
                    push.found   = 1'b1;
                    push.idx_a   = r_pend_a;
                    push.idx_b   = r_pend_b;
                    push.last    = 1'b0;
                    n_pend_valid = 1'b1;
                    n_pend_a     = r_ia[IDX_W-1:0];
                    n_pend_b     = r_ib[IDX_W-1:0];
                    n_ia         = r_ia + 1'b1;
                    n_ib         = r_ib + 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    // final pair, or the empty result when nothing matched
                    push.valid   = 1'b1;
                    push.found   = r_pend_valid;
                    push.idx_a   = r_pend_valid ? r_pend_a : '0;
                    push.idx_b   = r_pend_valid ? r_pend_b : '0;
                    push.last    = 1'b1;
                    n_pend_valid = 1'b0;
                    clear_run    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ovf        <= 1'b0;
            r_win_ps     <= WIN_PS_RESET;
            r_ia         <= '0;
            r_ib         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_pend_valid <= n_pend_valid;

            if (cfg_acc) begin
                r_win_ps <= WIN_W'({{(WIN_W - WIN_NS_W){1'b0}}, i_cfg_data} * PS_PER_NS);
            end

            // loads: append, or drop and flag overflow when full
            if (in_acc && (i_mode == MODE_LOAD_A)) begin
                if (we_a) begin
                    r_cnt_a <= r_cnt_a + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (in_acc && (i_mode == MODE_LOAD_B)) begin
                if (we_b) begin
                    r_cnt_b <= r_cnt_b + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (clear_run) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_ovf   <= 1'b0;
            end

            if (push.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_pend_a <= n_pend_a;
        r_pend_b <= n_pend_b;
        if (push.valid) begin
            r_out_found <= push.found;
            r_out_a     <= push.idx_a;
            r_out_b     <= push.idx_b;
            r_out_last  <= push.last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pair_found = r_out_found;
    assign o_index_a    = IDX_OUT_W'(r_out_a);
    assign o_index_b    = IDX_OUT_W'(r_out_b);
    assign o_last       = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

### hdl/ctcp_checker.sv
// Port-level assertions for the coincidence pairer, bound to the top level.
`timescale 1ns / 1ps

module ctcp_checker
    import ctcp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [MODE_W-1:0]     i_mode,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_pair_found,
    input logic [IDX_OUT_W-1:0]  o_index_a,
    input logic [IDX_OUT_W-1:0]  o_index_b,
    input logic                  o_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pair_found) && $stable(o_last)
            && $stable(o_index_a) && $stable(o_index_b))
        else $error("stalled result changed");

    // An empty result is the last result of its run, with both indices zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pair_found |-> o_last && (o_index_a == '0) && (o_index_b == '0))
        else $error("empty result not final or not zero");

    // A run item blocks the input while it walks
    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode == MODE_RUN) |=> o_stall)
        else $error("input not stalled after run item");

    // A load item never blocks the next item
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_mode != MODE_RUN) |=> !o_stall)
        else $error("input stalled after load item");

endmodule

bind two_channel_coincidence_pairer ctcp_checker u_ctcp_checker (.*);
